### sv/hrbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrbc_pkg;

   // Special characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_END   = 8'h00;

   // Parse phases
   localparam logic [3:0] PH_METHOD_START = 4'd0;
   localparam logic [3:0] PH_METHOD       = 4'd1;
   localparam logic [3:0] PH_URL_START    = 4'd2;
   localparam logic [3:0] PH_URL          = 4'd3;
   localparam logic [3:0] PH_VER_START    = 4'd4;
   localparam logic [3:0] PH_VER          = 4'd5;
   localparam logic [3:0] PH_REQ_REST     = 4'd6;
   localparam logic [3:0] PH_MALFORMED    = 4'd7;
   localparam logic [3:0] PH_HDR_START    = 4'd8;
   localparam logic [3:0] PH_HDR_NAME     = 4'd9;
   localparam logic [3:0] PH_VAL_START    = 4'd10;
   localparam logic [3:0] PH_VAL          = 4'd11;
   localparam logic [3:0] PH_BODY_START   = 4'd12;
   localparam logic [3:0] PH_BODY         = 4'd13;

   // Byte classes
   localparam logic [2:0] CL_METHOD  = 3'd0;
   localparam logic [2:0] CL_URL     = 3'd1;
   localparam logic [2:0] CL_VERSION = 3'd2;
   localparam logic [2:0] CL_NAME    = 3'd3;
   localparam logic [2:0] CL_VALUE   = 3'd4;
   localparam logic [2:0] CL_BODY    = 3'd5;
   localparam logic [2:0] CL_IGNORED = 3'd6;
   localparam logic [2:0] CL_END     = 3'd7;

   // Line events
   localparam logic [1:0] LE_NONE     = 2'd0;
   localparam logic [1:0] LE_COMPLETE = 2'd1;
   localparam logic [1:0] LE_DROPPED  = 2'd2;
   localparam logic [1:0] LE_HDR_END  = 2'd3;

   // Request line status
   localparam logic [1:0] ST_PENDING   = 2'd0;
   localparam logic [1:0] ST_OK        = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   typedef struct packed {
      logic [3:0] phase;
      logic       skip_one_space;
      logic       line_has_content;
      logic       after_cr;
      logic [1:0] status;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] byte_class;
      logic       field_start;
      logic [1:0] line_event;
      logic [1:0] request_status;
      logic       message_end;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:            PH_METHOD_START,
      skip_one_space:   1'b0,
      line_has_content: 1'b0,
      after_cr:         1'b0,
      status:           ST_PENDING
   };

endpackage

`default_nettype wire

### sv/http_request_byte_classifier_top.sv
// Accepted request bytes pass the input register, then the result register, to rsp_.
// Throughput: one byte per cycle; the input register, the one-level phase update and
// the result register keep pace with each other as long as rsp_ready stays high.
// Reset (synchronous, active high) empties both stages and returns the parser to the
// start of the method segment with status pending; a zero byte does the same in-band.
`timescale 1ns / 1ps
`default_nettype none

module http_request_byte_classifier_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_out,
   output logic [2:0]      rsp_byte_class,
   output logic            rsp_field_start,
   output logic [1:0]      rsp_line_event,
   output logic [1:0]      rsp_request_status,
   output logic            rsp_message_end
);
   import hrbc_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   result_type      out_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_in;
   logic            advance;

   // Move the held byte to the result register when that register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
   end

   hrbc_classify u_classify (
      .byte_in   (in_byte_ff),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (result_in)
   );

   // Parser state, updated once per classified byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_out       = out_ff.byte_out;
   assign rsp_byte_class     = out_ff.byte_class;
   assign rsp_field_start    = out_ff.field_start;
   assign rsp_line_event     = out_ff.line_event;
   assign rsp_request_status = out_ff.request_status;
   assign rsp_message_end    = out_ff.message_end;

   // A classified zero byte always leaves the parser in its reset state
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff == CH_END) |=> (state_ff == STATE_RESET))
      else $error("parser state not cleared after end byte");

   // End of headers can only follow a well-formed request line
   a_hdr_end_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_event == LE_HDR_END) |-> (rsp_request_status == ST_OK))
      else $error("headers end reported without a valid request line");

   // Field starts only on content bytes
   a_start_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_start) |->
         (rsp_byte_class != CL_IGNORED && rsp_byte_class != CL_END))
      else $error("field start on ignored or end byte");

   // Header and body phases are reached only with the request line accepted
   a_phase_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase >= PH_HDR_START) |-> (state_ff.status == ST_OK))
      else $error("header phase with bad request status");

endmodule

`default_nettype wire

### sv/hrbc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module hrbc_classify (
   input  wire logic [7:0]              byte_in,
   input  wire hrbc_pkg::parse_state_type cur_state,
   output hrbc_pkg::parse_state_type     nxt_state,
   output hrbc_pkg::result_type          result
);
   import hrbc_pkg::*;

   logic [3:0]      p;
   parse_state_type lf_state;
   logic [1:0]      lf_event;

   assign p = cur_state.phase;

   // Line feed: close the current line
   always_comb begin
      lf_state          = cur_state;
      lf_event          = LE_NONE;
      lf_state.after_cr = 1'b0;
      if (p <= PH_URL) begin
         lf_state.status = ST_MALFORMED;
         lf_state.phase  = PH_MALFORMED;
      end else if (p <= PH_REQ_REST) begin
         lf_state.phase = PH_HDR_START;
      end else if (p >= PH_HDR_START && p <= PH_VAL) begin
         if (!cur_state.line_has_content) begin
            lf_event       = LE_HDR_END;
            lf_state.phase = PH_BODY_START;
         end else begin
            lf_event       = (p == PH_HDR_NAME) ? LE_DROPPED : LE_COMPLETE;
            lf_state.phase = PH_HDR_START;
         end
         lf_state.line_has_content = 1'b0;
         lf_state.skip_one_space   = 1'b0;
      end
   end

   // Per-byte classification and phase update
   always_comb begin
      nxt_state                 = cur_state;
      result.byte_out           = byte_in;
      result.byte_class         = CL_IGNORED;
      result.field_start        = 1'b0;
      result.line_event         = LE_NONE;
      result.message_end        = 1'b0;
      result.request_status     = cur_state.status;

      if (byte_in == CH_END) begin
         // terminating zero: report, then back to reset state
         result.byte_class  = CL_END;
         result.message_end = 1'b1;
         result.request_status = (cur_state.status == ST_PENDING) ? ST_MALFORMED
                                                                  : cur_state.status;
         if (p >= PH_HDR_NAME && p <= PH_VAL && cur_state.line_has_content) begin
            result.line_event = (p == PH_HDR_NAME) ? LE_DROPPED : LE_COMPLETE;
         end
         nxt_state = STATE_RESET;
      end else begin
         if (p == PH_BODY_START || p == PH_BODY) begin
            result.byte_class  = CL_BODY;
            result.field_start = (p == PH_BODY_START);
            nxt_state.phase    = PH_BODY;
         end else if (p == PH_MALFORMED || p > PH_BODY) begin
            result.byte_class = CL_IGNORED;
         end else if (cur_state.after_cr) begin
            if (byte_in == CH_LF) begin
               nxt_state         = lf_state;
               result.line_event = lf_event;
            end
         end else if (byte_in == CH_LF) begin
            nxt_state         = lf_state;
            result.line_event = lf_event;
         end else if (byte_in == CH_CR) begin
            if (p <= PH_URL) begin
               nxt_state.status = ST_MALFORMED;
               nxt_state.phase  = PH_MALFORMED;
            end else begin
               nxt_state.after_cr = 1'b1;
            end
         end else if (p <= PH_REQ_REST) begin
            // request line segments
            if (p == PH_REQ_REST) begin
               result.byte_class = CL_IGNORED;
            end else if (byte_in == CH_SPACE) begin
               if (p <= PH_METHOD) begin
                  nxt_state.phase = PH_URL_START;
               end else if (p <= PH_URL) begin
                  nxt_state.phase  = PH_VER_START;
                  nxt_state.status = ST_OK;
               end else begin
                  nxt_state.phase = PH_REQ_REST;
               end
            end else begin
               result.byte_class  = (p <= PH_METHOD) ? CL_METHOD :
                                    (p <= PH_URL)    ? CL_URL : CL_VERSION;
               result.field_start = ~p[0];
               nxt_state.phase    = p | 4'd1;
            end
         end else if (p == PH_HDR_START || p == PH_HDR_NAME) begin
            nxt_state.line_has_content = 1'b1;
            if (byte_in == CH_COLON) begin
               nxt_state.phase          = PH_VAL_START;
               nxt_state.skip_one_space = 1'b1;
            end else begin
               result.byte_class  = CL_NAME;
               result.field_start = (p == PH_HDR_START);
               nxt_state.phase    = PH_HDR_NAME;
            end
         end else if (p == PH_VAL_START && cur_state.skip_one_space &&
                      byte_in == CH_SPACE) begin
            nxt_state.skip_one_space = 1'b0;
         end else begin
            result.byte_class        = CL_VALUE;
            result.field_start       = (p == PH_VAL_START);
            nxt_state.skip_one_space = 1'b0;
            nxt_state.phase          = PH_VAL;
         end
         result.request_status = nxt_state.status;
      end
   end

endmodule

`default_nettype wire

### dv/byte_class_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the HTTP byte classifier, predicts the tag of every
// accepted request byte and compares it with the response transactions in order.
module byte_class_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_byte_out,
   input  wire logic [2:0] rsp_byte_class,
   input  wire logic       rsp_field_start,
   input  wire logic [1:0] rsp_line_event,
   input  wire logic [1:0] rsp_request_status,
   input  wire logic       rsp_message_end,
   output int              mismatch_count,
   output int              pending_tags
);
   import hrbc_pkg::*;

   localparam int PRINT_CAP = 40;

   parse_state_type parser_state = STATE_RESET;
   result_type      expected_tags[$];
   int              tag_index = 0;

   initial begin
      mismatch_count = 0;
      pending_tags   = 0;
   end

   // One line per failure; keep the log short if the design is badly off
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want, input int idx);
      if (got != want)
         report_mismatch($sformatf("tag %0d: %s is %0d, expected %0d", idx, name, got, want));
   endtask

   // LF closes the current line; returns the line event it reports
   task automatic close_line(output logic [1:0] ev);
      logic [3:0] p;
      p  = parser_state.phase;
      ev = LE_NONE;
      parser_state.after_cr = 1'b0;
      if (p <= PH_URL) begin
         parser_state.status = ST_MALFORMED;
         parser_state.phase  = PH_MALFORMED;
      end else if (p <= PH_REQ_REST) begin
         parser_state.phase = PH_HDR_START;
      end else if (p >= PH_HDR_START && p <= PH_VAL) begin
         if (!parser_state.line_has_content) begin
            ev = LE_HDR_END;
            parser_state.phase = PH_BODY_START;
         end else begin
            ev = (p == PH_HDR_NAME) ? LE_DROPPED : LE_COMPLETE;
            parser_state.phase = PH_HDR_START;
         end
         parser_state.line_has_content = 1'b0;
         parser_state.skip_one_space   = 1'b0;
      end
   endtask

   // Advance the parser by one byte and build the tag it should produce
   task automatic classify_byte(input logic [7:0] b, output result_type tag);
      logic [3:0] p;
      logic [2:0] cls;
      logic       fs;
      logic [1:0] ev;
      logic       msg_end;
      p       = parser_state.phase;
      cls     = CL_IGNORED;
      fs      = 1'b0;
      ev      = LE_NONE;
      msg_end = 1'b0;

      if (b == CH_END) begin
         cls     = CL_END;
         msg_end = 1'b1;
         if (parser_state.status == ST_PENDING)
            parser_state.status = ST_MALFORMED;
         if (p >= PH_HDR_NAME && p <= PH_VAL && parser_state.line_has_content)
            ev = (p == PH_HDR_NAME) ? LE_DROPPED : LE_COMPLETE;
      end else if (p == PH_BODY_START || p == PH_BODY) begin
         cls = CL_BODY;
         fs  = (p == PH_BODY_START);
         parser_state.phase = PH_BODY;
      end else if (p == PH_MALFORMED || p > PH_BODY) begin
         cls = CL_IGNORED;
      end else if (parser_state.after_cr) begin
         // tail after CR is dropped up to the LF
         if (b == CH_LF)
            close_line(ev);
      end else if (b == CH_LF) begin
         close_line(ev);
      end else if (b == CH_CR) begin
         if (p <= PH_URL) begin
            parser_state.status = ST_MALFORMED;
            parser_state.phase  = PH_MALFORMED;
         end else begin
            parser_state.after_cr = 1'b1;
         end
      end else if (p <= PH_REQ_REST) begin
         // request line: method, url, version split by spaces
         if (p == PH_REQ_REST) begin
            cls = CL_IGNORED;
         end else if (b == CH_SPACE) begin
            if (p <= PH_METHOD) begin
               parser_state.phase = PH_URL_START;
            end else if (p <= PH_URL) begin
               parser_state.phase  = PH_VER_START;
               parser_state.status = ST_OK;
            end else begin
               parser_state.phase = PH_REQ_REST;
            end
         end else begin
            cls = (p <= PH_METHOD) ? CL_METHOD : (p <= PH_URL) ? CL_URL : CL_VERSION;
            fs  = ~p[0];
            parser_state.phase = p | 4'd1;
         end
      end else if (p == PH_HDR_START || p == PH_HDR_NAME) begin
         parser_state.line_has_content = 1'b1;
         if (b == CH_COLON) begin
            parser_state.phase          = PH_VAL_START;
            parser_state.skip_one_space = 1'b1;
         end else begin
            cls = CL_NAME;
            fs  = (p == PH_HDR_START);
            parser_state.phase = PH_HDR_NAME;
         end
      end else if (p == PH_VAL_START && parser_state.skip_one_space && b == CH_SPACE) begin
         parser_state.skip_one_space = 1'b0;
      end else begin
         cls = CL_VALUE;
         fs  = (p == PH_VAL_START);
         parser_state.skip_one_space = 1'b0;
         parser_state.phase          = PH_VAL;
      end

      tag.byte_out       = b;
      tag.byte_class     = cls;
      tag.field_start    = fs;
      tag.line_event     = ev;
      tag.request_status = parser_state.status;
      tag.message_end    = msg_end;

      if (msg_end)
         parser_state = STATE_RESET;
   endtask

   // Predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      result_type tag;
      result_type want;
      if (reset) begin
         parser_state = STATE_RESET;
         expected_tags.delete();
      end else begin
         if (req_valid && req_ready) begin
            classify_byte(req_byte_in, tag);
            expected_tags.push_back(tag);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               report_mismatch($sformatf("tag %0d arrived with nothing expected", tag_index));
            end else begin
               want = expected_tags.pop_front();
               check_field("byte_out", rsp_byte_out, want.byte_out, tag_index);
               check_field("byte_class", rsp_byte_class, want.byte_class, tag_index);
               check_field("field_start", rsp_field_start, want.field_start, tag_index);
               check_field("line_event", rsp_line_event, want.line_event, tag_index);
               check_field("request_status", rsp_request_status, want.request_status,
                           tag_index);
               check_field("message_end", rsp_message_end, want.message_end, tag_index);
            end
            tag_index++;
         end
      end
      pending_tags = expected_tags.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import hrbc_pkg::*;

   localparam int BYTE_TARGET = 1300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_TAIL  = 8;

   typedef enum {RX_ALWAYS, RX_COIN, RX_QUARTER, RX_TRICKLE} rx_mode_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_ready   = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_byte_out;
   logic [2:0] rsp_byte_class;
   logic       rsp_field_start;
   logic [1:0] rsp_line_event;
   logic [1:0] rsp_request_status;
   logic       rsp_message_end;

   int mismatch_count;
   int pending_tags;
   int sent_count  = 0;
   int burst_left  = 0;
   int cycle_count = 0;

   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_left = 0;
   int          rx_tick = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   http_request_byte_classifier_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_byte_class     (rsp_byte_class),
      .rsp_field_start    (rsp_field_start),
      .rsp_line_event     (rsp_line_event),
      .rsp_request_status (rsp_request_status),
      .rsp_message_end    (rsp_message_end)
   );

   byte_class_checker class_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_byte_class     (rsp_byte_class),
      .rsp_field_start    (rsp_field_start),
      .rsp_line_event     (rsp_line_event),
      .rsp_request_status (rsp_request_status),
      .rsp_message_end    (rsp_message_end),
      .mismatch_count     (mismatch_count),
      .pending_tags       (pending_tags)
   );

   // Receiver backpressure: switch between stall patterns every so often
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end else begin
         rx_left--;
      end
      rx_tick++;
      case (rx_mode)
         RX_ALWAYS:  rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RX_QUARTER: rsp_ready <= (rx_tick % 4 == 0);
         default:    rsp_ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Send one byte transaction; called at a falling edge, returns at one.
   // The sender runs in bursts with random gaps between them.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 3);
            default: gap = $urandom_range(4, 12);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // Token byte: mostly lowercase, sometimes any byte that is not a delimiter
   function automatic logic [7:0] token_byte();
      logic [7:0] b;
      if ($urandom_range(0, 3) != 0) begin
         b = 8'($urandom_range(8'h61, 8'h7A));
      end else begin
         b = 8'($urandom_range(1, 255));
         while (b == CH_SPACE || b == CH_CR || b == CH_LF || b == CH_COLON)
            b = 8'($urandom_range(1, 255));
      end
      return b;
   endfunction

   task automatic send_token(input int unsigned len);
      repeat (len) push_byte(token_byte());
   endtask

   // Header values may carry colons and spaces
   task automatic send_value(input int unsigned len);
      repeat (len) begin
         if ($urandom_range(0, 5) == 0)
            push_byte($urandom_range(0, 1) ? CH_COLON : CH_SPACE);
         else
            push_byte(token_byte());
      end
   endtask

   // Line ending: CRLF, bare LF, or CR with a junk tail before the LF
   task automatic end_line();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         push_byte(CH_CR);
         push_byte(CH_LF);
      end else if (pick < 9) begin
         push_byte(CH_LF);
      end else begin
         push_byte(CH_CR);
         send_value($urandom_range(1, 3));
         push_byte(CH_LF);
      end
   endtask

   // Well-formed request with random content, sometimes cut short
   task automatic send_request();
      int n_hdr;
      int pick;
      send_token(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7));
      push_byte(CH_SPACE);
      send_token(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
      push_byte(CH_SPACE);
      send_token(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) begin
         push_byte(CH_SPACE);
         send_value($urandom_range(0, 4));
      end
      end_line();

      n_hdr = $urandom_range(0, 5);
      repeat (n_hdr) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_token($urandom_range(1, 8));
         end else if (pick == 1) begin
            push_byte(CH_COLON);
            send_value($urandom_range(0, 6));
         end else begin
            send_token($urandom_range(1, 10));
            push_byte(CH_COLON);
            if ($urandom_range(0, 3) != 0)
               push_byte(CH_SPACE);
            send_value($urandom_range(0, 12));
         end
         end_line();
      end

      // message ends inside an open header line
      if ($urandom_range(0, 7) == 0) begin
         pick = $urandom_range(0, 2);
         if (pick != 0)
            send_token($urandom_range(1, 5));
         if (pick == 2) begin
            push_byte(CH_COLON);
            send_value($urandom_range(0, 4));
         end
      end else begin
         end_line();
         repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(1, 255)));
      end
      push_byte(CH_END);
   endtask

   // Noise: delimiter-heavy junk, exercising short and broken request lines
   task automatic send_noise();
      int pick;
      repeat ($urandom_range(0, 15)) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       push_byte(CH_SPACE);
            1:       push_byte(CH_CR);
            2:       push_byte(CH_LF);
            3:       push_byte(CH_COLON);
            default: push_byte(8'($urandom_range(1, 255)));
         endcase
      end
      push_byte(CH_END);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty method, extra space after the version, bare LF
      send_text(" a b c\n");
      // Skipped space, colon in the value, top byte value, junk after CR
      send_text("k: v:");
      push_byte(8'hFF);
      send_text("\rz\n");
      // Dropped line, empty line, body with delimiters, terminating zero
      send_text("q\n\n\r: ");
      push_byte(CH_END);
      // Short request line, then ignored bytes
      send_text("x\ny");
      push_byte(CH_END);
      // Empty header name, zero inside a header line
      send_text("m u v\n:w");
      push_byte(CH_END);

      while (sent_count < BYTE_TARGET) begin
         if ($urandom_range(0, 4) == 0)
            send_noise();
         else
            send_request();
      end
      req_valid <= 1'b0;

      while (pending_tags != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
sv/hrbc_pkg.sv
sv/hrbc_classify.sv
sv/http_request_byte_classifier_top.sv
dv/byte_class_checker.sv
dv/tb.sv
